### hw/rtl/afc_pkg.sv
// ============================================================================
// afc_pkg
// Shared types, widths and codes for the box-versus-frustum classifier.
// ============================================================================
package afc_pkg;

  // Default plane store depth
  localparam int unsigned PLANE_COUNT_DEF = 6;

  // Field widths
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned NORM_W   = 16;
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned OFF_W    = 32;
  localparam int unsigned PROD_W   = NORM_W + COORD_W;
  localparam int unsigned FRAC_SH  = 14;
  localparam int unsigned ACC_W    = 50;
  localparam int unsigned CLASS_W  = 2;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 280;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_TDATA_W = 8;

  // Command codes carried in tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  // Result codes
  localparam logic [CLASS_W-1:0] CLASS_INSIDE    = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_INTERSECT = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_OUTSIDE   = 2'd2;

  // Axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Tag issued with each product
  typedef struct packed {
    logic valid;
    logic first;       // first product of a plane
    logic last_axis;   // last product of a plane
    logic to_near;     // product belongs to the near-corner sum
    logic last_plane;  // plane is the last one of the store
  } mac_tag_t;

  // Per-plane verdict from the accumulator
  typedef struct packed {
    logic done;
    logic last_plane;
    logic outside;
    logic straddle;
  } mac_res_t;

endpackage

### hw/rtl/afc_plane_store.sv
// ============================================================================
// afc_plane_store
// Register store of plane normals and offsets, one write and one read port.
// ============================================================================
module afc_plane_store #(
  parameter int unsigned PLANE_COUNT = afc_pkg::PLANE_COUNT_DEF,
  parameter int unsigned PW          = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  wr_en_i,
  input  logic [afc_pkg::IDX_W-1:0]             wr_idx_i,
  input  logic [3*afc_pkg::NORM_W-1:0]          wr_normal_i,
  input  logic [afc_pkg::OFF_W-1:0]             wr_offset_i,
  input  logic [PW-1:0]                         rd_idx_i,
  output logic [3*afc_pkg::NORM_W-1:0]          rd_normal_o,
  output logic [afc_pkg::OFF_W-1:0]             rd_offset_o
);
  import afc_pkg::*;

  localparam int unsigned CMP_W = (IDX_W > PW) ? IDX_W : PW;

  logic [3*NORM_W-1:0] normal_q [PLANE_COUNT];
  logic [OFF_W-1:0]    offset_q [PLANE_COUNT];

  // Write the addressed slot; out-of-range indexes match no slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < PLANE_COUNT; e++) begin
        normal_q[e] <= '0;
        offset_q[e] <= '0;
      end
    end else if (wr_en_i) begin
      for (int e = 0; e < PLANE_COUNT; e++) begin
        if (CMP_W'(wr_idx_i) == CMP_W'(e)) begin
          normal_q[e] <= wr_normal_i;
          offset_q[e] <= wr_offset_i;
        end
      end
    end
  end

  // Read the plane under evaluation
  assign rd_normal_o = normal_q[rd_idx_i];
  assign rd_offset_o = offset_q[rd_idx_i];

endmodule

### hw/rtl/afc_mac_unit.sv
// ============================================================================
// afc_mac_unit
// Shared multiplier and accumulator: one product a cycle, near and far sums
// per plane, and a verdict when the last product of a plane lands.
// ============================================================================
module afc_mac_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  afc_pkg::mac_tag_t                    tag_i,
  input  logic signed [afc_pkg::NORM_W-1:0]    normal_i,
  input  logic signed [afc_pkg::COORD_W-1:0]   coord_i,
  input  logic signed [afc_pkg::OFF_W-1:0]     offset_i,
  output afc_pkg::mac_res_t                    res_o
);
  import afc_pkg::*;

  mac_tag_t                  tag_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [OFF_W-1:0]   off_q;
  logic signed [ACC_W-1:0]   acc_near_q, acc_near_d;
  logic signed [ACC_W-1:0]   acc_far_q, acc_far_d;
  logic signed [ACC_W-1:0]   off_ext;
  logic signed [ACC_W-1:0]   base;
  logic signed [ACC_W-1:0]   sum;

  // Multiply stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= normal_i * coord_i;
    off_q  <= offset_i;
  end

  // Accumulate stage: a plane's first product seeds both sums with the offset
  always_comb begin
    off_ext    = {{(ACC_W-OFF_W-FRAC_SH){off_q[OFF_W-1]}}, off_q, {FRAC_SH{1'b0}}};
    base       = tag_q.first ? off_ext : (tag_q.to_near ? acc_near_q : acc_far_q);
    sum        = base + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    acc_near_d = acc_near_q;
    acc_far_d  = acc_far_q;
    if (tag_q.valid) begin
      if (tag_q.first) begin
        acc_near_d = tag_q.to_near ? sum : off_ext;
        acc_far_d  = tag_q.to_near ? off_ext : sum;
      end else if (tag_q.to_near) begin
        acc_near_d = sum;
      end else begin
        acc_far_d = sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_near_q <= acc_near_d;
    acc_far_q  <= acc_far_d;
  end

  // Verdict: near corner beyond the plane, or far corner on or beyond it
  assign res_o.done       = tag_q.valid & tag_q.last_axis;
  assign res_o.last_plane = tag_q.last_plane;
  assign res_o.outside    = ~acc_near_d[ACC_W-1] & (|acc_near_d);
  assign res_o.straddle   = ~acc_far_d[ACC_W-1];

endmodule

### hw/rtl/aabb_frustum_classify_top.sv
// ============================================================================
// aabb_frustum_classify_top
// Classifies an axis-aligned box against a store of frustum planes.
// ============================================================================
// Usage:
//   Slave stream: tuser selects the transaction kind. A load writes one plane
//   (index, Q1.14 normal, Q16.16 offset) and gives no result; a test carries a
//   Q16.16 box and gives one result on the master stream: 0 inside,
//   1 intersects, 2 outside.
//   A load leaves the block ready for the next transaction. A test runs
//   one signed 16x32 multiplier for six products per plane (the low and high
//   box coordinate on each axis): the sequencer issues the products, waits
//   for the last plane's verdict and then writes the result to the output
//   register; the block takes no new transaction until that write is done.
//   The multiplier is the bottleneck.
//   Reset clears the plane store to zero, so every test answers intersects
//   until planes are loaded. Loads with an index at or above PLANE_COUNT are
//   dropped.
//   While the output register holds an untaken result, loads and a further
//   test are still accepted; a finished test then waits for the register to
//   drain, with tready low.
// ============================================================================
module aabb_frustum_classify_top #(
  parameter int unsigned PLANE_COUNT = afc_pkg::PLANE_COUNT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata, low bit up: plane_index[3], normal_x[16], normal_y[16],
  // normal_z[16], plane_offset[32], box_min_x/y/z[32 each],
  // box_max_x/y/z[32 each], zero fill to 280
  input  logic [afc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tuser: command[1]
  input  logic [afc_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata, low bit up: bound_class[2], zero fill to 8
  output logic [afc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import afc_pkg::*;

  localparam int unsigned PW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]               state_q, state_d;
  logic [PW-1:0]            plane_q, plane_d;
  logic [1:0]               axis_q, axis_d;
  logic                     side_q, side_d;
  logic                     outside_q, outside_d;
  logic                     straddle_q, straddle_d;
  logic                     out_valid_q, out_valid_d;
  logic [CLASS_W-1:0]       out_class_q, out_class_d;
  logic [COORD_W-1:0]       box_lo_q [3];
  logic [COORD_W-1:0]       box_hi_q [3];

  logic                     in_fire;
  logic                     load_fire;
  logic                     test_fire;
  logic [3*NORM_W-1:0]      rd_normal;
  logic [OFF_W-1:0]         rd_offset;
  logic [NORM_W-1:0]        cur_normal;
  logic [COORD_W-1:0]       cur_coord;
  logic                     n_pos;
  logic                     last_plane;
  mac_tag_t                 tag;
  mac_res_t                 res;

  assign in_fire   = s_axis_tvalid & s_axis_tready;
  assign load_fire = in_fire & (s_axis_tuser[0] == CMD_LOAD);
  assign test_fire = in_fire & (s_axis_tuser[0] == CMD_TEST);

  // Plane store
  afc_plane_store #(
    .PLANE_COUNT (PLANE_COUNT),
    .PW          (PW)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (load_fire),
    .wr_idx_i    (s_axis_tdata[2:0]),
    .wr_normal_i (s_axis_tdata[50:3]),
    .wr_offset_i (s_axis_tdata[82:51]),
    .rd_idx_i    (plane_q),
    .rd_normal_o (rd_normal),
    .rd_offset_o (rd_offset)
  );

  // Capture the box of an accepted test
  always_ff @(posedge clk_i) begin
    if (test_fire) begin
      box_lo_q[0] <= s_axis_tdata[114:83];
      box_lo_q[1] <= s_axis_tdata[146:115];
      box_lo_q[2] <= s_axis_tdata[178:147];
      box_hi_q[0] <= s_axis_tdata[210:179];
      box_hi_q[1] <= s_axis_tdata[242:211];
      box_hi_q[2] <= s_axis_tdata[274:243];
    end
  end

  // Select operands for this step
  always_comb begin
    case (axis_q)
      AXIS_X: begin
        cur_normal = rd_normal[NORM_W-1:0];
        cur_coord  = side_q ? box_hi_q[0] : box_lo_q[0];
      end
      AXIS_Y: begin
        cur_normal = rd_normal[2*NORM_W-1:NORM_W];
        cur_coord  = side_q ? box_hi_q[1] : box_lo_q[1];
      end
      default: begin
        cur_normal = rd_normal[3*NORM_W-1:2*NORM_W];
        cur_coord  = side_q ? box_hi_q[2] : box_lo_q[2];
      end
    endcase
  end

  // Near corner takes the low coordinate where the normal is positive
  assign n_pos      = ~cur_normal[NORM_W-1] & (|cur_normal);
  assign last_plane = (plane_q == PW'(PLANE_COUNT - 1));

  always_comb begin
    tag.valid      = (state_q == S_RUN);
    tag.first      = (axis_q == AXIS_X) & ~side_q;
    tag.last_axis  = (axis_q == AXIS_Z) & side_q;
    tag.to_near    = side_q ? ~n_pos : n_pos;
    tag.last_plane = last_plane;
  end

  // Shared multiply-accumulate unit
  afc_mac_unit u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (tag),
    .normal_i (cur_normal),
    .coord_i  (cur_coord),
    .offset_i (rd_offset),
    .res_o    (res)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    plane_d     = plane_q;
    axis_d      = axis_q;
    side_d      = side_q;
    outside_d   = outside_q;
    straddle_d  = straddle_q;
    out_valid_d = out_valid_q;
    out_class_d = out_class_q;

    // Release the output on a completed transaction
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    // Fold in each plane's verdict
    if (res.done) begin
      outside_d  = outside_q | res.outside;
      straddle_d = straddle_q | res.straddle;
    end

    unique case (state_q)
      S_IDLE: begin
        if (test_fire) begin
          state_d    = S_RUN;
          plane_d    = '0;
          axis_d     = AXIS_X;
          side_d     = 1'b0;
          outside_d  = 1'b0;
          straddle_d = 1'b0;
        end
      end
      S_RUN: begin
        side_d = ~side_q;
        if (side_q) begin
          if (axis_q == AXIS_Z) begin
            axis_d = AXIS_X;
            if (last_plane) begin
              state_d = S_DRAIN;
            end else begin
              plane_d = plane_q + 1'b1;
            end
          end else begin
            axis_d = axis_q + 1'b1;
          end
        end
      end
      S_DRAIN: begin
        if (res.done && res.last_plane) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_class_d = outside_q  ? CLASS_OUTSIDE :
                        straddle_q ? CLASS_INTERSECT : CLASS_INSIDE;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      plane_q     <= '0;
      axis_q      <= AXIS_X;
      side_q      <= 1'b0;
      outside_q   <= 1'b0;
      straddle_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      plane_q     <= plane_d;
      axis_q      <= axis_d;
      side_q      <= side_d;
      outside_q   <= outside_d;
      straddle_q  <= straddle_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_class_q <= out_class_d;
  end

  // Drive the streams
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-CLASS_W){1'b0}}, out_class_q};

endmodule

### hw/rtl/afc_checker.sv
// ============================================================================
// afc_checker
// Port-level checks on the classifier, bound to the top level.
// ============================================================================
module afc_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  input  logic [afc_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic [afc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import afc_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed or dropped");

  // Only defined class codes leave the block
  a_class_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[CLASS_W-1:0] == CLASS_INSIDE ||
                       m_axis_tdata[CLASS_W-1:0] == CLASS_INTERSECT ||
                       m_axis_tdata[CLASS_W-1:0] == CLASS_OUTSIDE))
    else $error("undefined class code");

  // A test occupies the block
  a_test_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == CMD_TEST) |=> !s_axis_tready)
    else $error("ready after test acceptance");

  // A load leaves the block ready
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == CMD_LOAD) |=> s_axis_tready)
    else $error("load stalled the input");

  // A new result follows a busy spell
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without a test in flight");

endmodule

bind aabb_frustum_classify_top afc_checker u_afc_checker (.*);

### sim/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for aabb_frustum_classify_top. Plane loads and box tests
// are driven on the slave stream. A mirror of the plane store predicts the
// class of every accepted test. Each master stream transaction is checked
// against the oldest prediction. Directed cases run first, then random
// frustum and box traffic under three idling mixes.
// ============================================================================
module testbench;
  import afc_pkg::*;

  localparam int unsigned PLANES   = PLANE_COUNT_DEF;
  localparam int          ONE_Q16  = 65536;
  localparam int          UNIT_NRM = 16384;

  // Slave stream payload, declared high field first so that the packed
  // layout matches tdata with plane_index in the lowest bits
  typedef struct packed {
    logic signed [COORD_W-1:0] max_z;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_x;
    logic signed [OFF_W-1:0]   ofs;
    logic signed [NORM_W-1:0]  nz;
    logic signed [NORM_W-1:0]  ny;
    logic signed [NORM_W-1:0]  nx;
    logic        [IDX_W-1:0]   idx;
  } afc_item_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // tdata, low bit up: plane_index, normal_x/y/z, plane_offset,
  // box_min_x/y/z, box_max_x/y/z, zero fill
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // tuser: command
  logic [IN_TUSER_W-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // tdata, low bit up: bound_class, zero fill
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Mirror of the plane store and the classes still to come back
  logic signed [NORM_W-1:0] nrm_mirror [PLANES][3];
  logic signed [OFF_W-1:0]  ofs_mirror [PLANES];
  logic [CLASS_W-1:0]       class_expected_q [$];

  int errors;
  int items_sent;
  int n_loads;
  int n_tests;
  int class_seen [3];
  int send_idle_pct;
  int recv_idle_pct;

  aabb_frustum_classify_top #(
    .PLANE_COUNT(PLANES)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Give up after a generous fixed time
  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d classes outstanding", $time, class_expected_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Classify a box against the mirrored planes: outside wins over intersect
  function automatic logic [CLASS_W-1:0] classify_box(afc_item_t it);
    longint lo [3];
    longint hi [3];
    longint n;
    longint d_near;
    longint d_far;
    bit     outside;
    bit     straddle;
    lo[0] = it.min_x;
    lo[1] = it.min_y;
    lo[2] = it.min_z;
    hi[0] = it.max_x;
    hi[1] = it.max_y;
    hi[2] = it.max_z;
    outside  = 1'b0;
    straddle = 1'b0;
    for (int p = 0; p < PLANES; p++) begin
      d_near = longint'(ofs_mirror[p]) * UNIT_NRM;
      d_far  = d_near;
      for (int a = 0; a < 3; a++) begin
        n = nrm_mirror[p][a];
        // Near corner takes the minimum only where the component is positive
        if (n > 0) begin
          d_near += n * lo[a];
          d_far  += n * hi[a];
        end else begin
          d_near += n * hi[a];
          d_far  += n * lo[a];
        end
      end
      if (d_near > 0) begin
        outside = 1'b1;
      end else if (d_far >= 0) begin
        straddle = 1'b1;
      end
    end
    if (outside) begin
      return CLASS_OUTSIDE;
    end
    return straddle ? CLASS_INTERSECT : CLASS_INSIDE;
  endfunction

  function automatic afc_item_t random_fields();
    afc_item_t it;
    it.idx   = IDX_W'($urandom);
    it.nx    = NORM_W'($urandom);
    it.ny    = NORM_W'($urandom);
    it.nz    = NORM_W'($urandom);
    it.ofs   = $urandom;
    it.min_x = $urandom;
    it.min_y = $urandom;
    it.min_z = $urandom;
    it.max_x = $urandom;
    it.max_y = $urandom;
    it.max_z = $urandom;
    return it;
  endfunction

  // Offer one transaction, hold it until accepted, then update the mirror
  task automatic send_item(input logic cmd, input afc_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(IN_TDATA_W - $bits(afc_item_t)){1'b0}}, it};
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd == CMD_LOAD) begin
      if (it.idx < PLANES) begin
        nrm_mirror[it.idx][0] = it.nx;
        nrm_mirror[it.idx][1] = it.ny;
        nrm_mirror[it.idx][2] = it.nz;
        ofs_mirror[it.idx]    = it.ofs;
        items_sent++;
        n_loads++;
      end
    end else begin
      class_expected_q.push_back(classify_box(it));
      items_sent++;
      n_tests++;
    end
    @(negedge clk_i);
  endtask

  // Load one plane; the box fields carry random filler
  task automatic load_plane(input logic [IDX_W-1:0] idx, input logic [NORM_W-1:0] nx,
                            input logic [NORM_W-1:0] ny, input logic [NORM_W-1:0] nz,
                            input logic [OFF_W-1:0] ofs);
    afc_item_t it;
    it     = random_fields();
    it.idx = idx;
    it.nx  = nx;
    it.ny  = ny;
    it.nz  = nz;
    it.ofs = ofs;
    send_item(CMD_LOAD, it);
  endtask

  // Test one box; the plane fields carry random filler
  task automatic test_box(input int lx, input int ly, input int lz,
                          input int hx, input int hy, input int hz);
    afc_item_t it;
    it       = random_fields();
    it.min_x = lx;
    it.min_y = ly;
    it.min_z = lz;
    it.max_x = hx;
    it.max_y = hy;
    it.max_z = hz;
    send_item(CMD_TEST, it);
  endtask

  // Hold the sender until every predicted class has come back
  task automatic wait_results_drained();
    while (class_expected_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Load a box-like frustum: near axis-aligned planes, small tilt, random reach, now and then a fully random plane
  task automatic load_frustum();
    int comp [3];
    int axis;
    int reach;
    for (int p = 0; p < PLANES; p++) begin
      axis = p / 2;
      for (int a = 0; a < 3; a++) begin
        comp[a] = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(6000)) - 3000;
      end
      comp[axis] = (UNIT_NRM - int'($urandom_range(2000))) * ((p % 2) ? -1 : 1);
      reach      = int'($urandom_range(200 * ONE_Q16, ONE_Q16));
      if ($urandom_range(7) == 0) begin
        load_plane(IDX_W'(p), NORM_W'($urandom), NORM_W'($urandom), NORM_W'($urandom),
                   $urandom);
      end else begin
        load_plane(IDX_W'(p), NORM_W'(comp[0]), NORM_W'(comp[1]), NORM_W'(comp[2]),
                   OFF_W'(-reach));
      end
    end
    // Drop in a load to an unused slot now and then
    if ($urandom_range(3) == 0) begin
      load_plane(IDX_W'($urandom_range(7, PLANES)), NORM_W'($urandom), NORM_W'($urandom),
                 NORM_W'($urandom), $urandom);
    end
  endtask

  // Box around a random centre, sometimes inverted on one axis
  task automatic random_box();
    int lo [3];
    int hi [3];
    int c;
    int h;
    int t;
    int a;
    for (int k = 0; k < 3; k++) begin
      c     = int'($urandom_range(500 * ONE_Q16)) - 250 * ONE_Q16;
      h     = int'($urandom_range(100 * ONE_Q16));
      lo[k] = c - h;
      hi[k] = c + h;
    end
    if ($urandom_range(9) == 0) begin
      a     = $urandom_range(2);
      t     = lo[a];
      lo[a] = hi[a];
      hi[a] = t;
    end
    test_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  // ---------------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------------

  // Cleared store: every plane straddles, so a test gives intersect
  task automatic test_reset_state();
    test_box(-ONE_Q16, -ONE_Q16, -ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16);
  endtask

  // Cube of half size ten: inside, outside, straddle and inverted boxes
  task automatic test_cube_planes();
    for (int p = 0; p < PLANES; p++) begin
      load_plane(IDX_W'(p),
                 (p / 2 == 0) ? NORM_W'((p % 2) ? -UNIT_NRM : UNIT_NRM) : '0,
                 (p / 2 == 1) ? NORM_W'((p % 2) ? -UNIT_NRM : UNIT_NRM) : '0,
                 (p / 2 == 2) ? NORM_W'((p % 2) ? -UNIT_NRM : UNIT_NRM) : '0,
                 OFF_W'(-10 * ONE_Q16));
    end
    test_box(-ONE_Q16, -ONE_Q16, -ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16);
    test_box(20 * ONE_Q16, -ONE_Q16, -ONE_Q16, 30 * ONE_Q16, ONE_Q16, ONE_Q16);
    test_box(5 * ONE_Q16, -ONE_Q16, -ONE_Q16, 15 * ONE_Q16, ONE_Q16, ONE_Q16);
    test_box(2 * ONE_Q16, 2 * ONE_Q16, 2 * ONE_Q16, -2 * ONE_Q16, -2 * ONE_Q16, -2 * ONE_Q16);
  endtask

  // Loads beyond the store must leave every plane untouched
  task automatic test_ignored_loads();
    load_plane(3'd6, 16'h8000, 16'h8000, 16'h8000, 32'h7fff_ffff);
    load_plane(3'd7, 16'h7fff, 16'h7fff, 16'h7fff, 32'h8000_0000);
    test_box(-ONE_Q16, -ONE_Q16, -ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16);
  endtask

  // Extreme normals and offsets, a zero plane, zero components, extreme boxes
  task automatic test_field_extremes();
    load_plane(3'd0, 16'h8000, 16'h0000, 16'h0000, 32'h7fff_ffff);
    load_plane(3'd1, 16'h7fff, 16'h7fff, 16'h7fff, 32'h8000_0000);
    test_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    test_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    load_plane(3'd2, '0, '0, '0, '0);
    test_box(-ONE_Q16, -ONE_Q16, -ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16);
    test_box(0, 0, 0, 0, 0, 0);
  endtask

  // Frustum loads followed by box tests, with some noise transactions
  task automatic test_random_traffic(input int count, input int spct, input int rpct,
                                     input bit hold_off);
    int goal;
    int r;
    bit held;
    send_idle_pct = spct;
    recv_idle_pct = rpct;
    goal = items_sent + count;
    held = 1'b0;
    load_frustum();
    while (items_sent < goal) begin
      r = $urandom_range(99);
      if (r < 10) begin
        load_frustum();
      end else if (r < 20) begin
        send_item(1'($urandom), random_fields());
      end else begin
        random_box();
      end
      if (hold_off && !held && items_sent >= goal - count / 2) begin
        s_axis_tvalid <= 1'b0;
        wait_results_drained();
        held = 1'b1;
      end
    end
  endtask

  // Receiver: drop tready at random as the current mix asks
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each master stream transaction with the oldest predicted class
  initial begin
    logic [CLASS_W-1:0] want;
    logic [CLASS_W-1:0] got;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
        got = m_axis_tdata[CLASS_W-1:0];
        if (class_expected_q.size() == 0) begin
          errors++;
          $display("%0t: bound_class mismatch, expected none, actual %0d", $time, got);
        end else begin
          want = class_expected_q.pop_front();
          class_seen[want]++;
          if (got !== want) begin
            errors++;
            $display("%0t: bound_class mismatch, expected %0d, actual %0d", $time, want, got);
          end
        end
      end
    end
  end

  // Main sequence
  initial begin
    errors        = 0;
    items_sent    = 0;
    n_loads       = 0;
    n_tests       = 0;
    class_seen    = '{0, 0, 0};
    send_idle_pct = 14;
    recv_idle_pct = 83;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    for (int p = 0; p < PLANES; p++) begin
      nrm_mirror[p] = '{'0, '0, '0};
      ofs_mirror[p] = '0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_cube_planes();
    test_ignored_loads();
    test_field_extremes();
    test_random_traffic(220, 14, 83, 1'b1);
    test_random_traffic(220, 83, 14, 1'b0);
    test_random_traffic(210, 0, 0, 1'b0);

    // Drain, then allow for a test still in flight
    s_axis_tvalid <= 1'b0;
    wait_results_drained();
    repeat (6 * PLANES + 12) @(posedge clk_i);
    if (class_expected_q.size() != 0) begin
      errors++;
      $display("%0t: %0d predicted classes never arrived", $time, class_expected_q.size());
    end

    $display("Sent %0d plane loads and %0d box tests over three idling mixes,",
             n_loads, n_tests);
    $display("classes checked: %0d inside, %0d intersect, %0d outside; %0d failures.",
             class_seen[CLASS_INSIDE], class_seen[CLASS_INTERSECT],
             class_seen[CLASS_OUTSIDE], errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
